[src/iova_range_allocator_defines.svh]
// assertion macros shared by the allocator rtl
// depends on a clock named clock and a reset named reset in the including scope
`ifndef IOVA_RANGE_ALLOCATOR_DEFINES_SVH
`define IOVA_RANGE_ALLOCATOR_DEFINES_SVH

// same-cycle implication, checked outside reset
`define IRA_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked outside reset
`define IRA_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[src/ira_pkg.sv]
// types, constants and codes of the iova range allocator
// no dependencies
package ira_pkg;

   localparam int DEF_TABLE_DEPTH    = 64;
   localparam int DEF_IOVA_BITS      = 39;
   localparam int DEF_PAGE_SHIFT     = 12;
   localparam int DEF_HOST_ADDR_BITS = 48;

   localparam int FLOOR_BYTES = 32'h10000;
   localparam int HOST_PAGE_W = 36;
   localparam int SIZE_W      = 28;
   localparam int IOVA_W      = 27;
   localparam int RANGE_W     = 28;
   localparam int STATUS_W    = 4;

   typedef enum logic [1:0] {
      MODE_MAP_FIXED = 2'd0,
      MODE_MAP_TEMP  = 2'd1,
      MODE_UNMAP     = 2'd2,
      MODE_RELEASE   = 2'd3
   } mode_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_NEW       = 4'd0,
      ST_HIT       = 4'd1,
      ST_UNMAPPED  = 4'd2,
      ST_RELEASED  = 4'd3,
      ST_NOT_FOUND = 4'd4,
      ST_NO_SPACE  = 4'd5,
      ST_OVERLAP   = 4'd6,
      ST_REFUSED   = 4'd7,
      ST_FULL      = 4'd8
   } status_type;

   typedef enum logic [2:0] {
      OP_NONE,
      OP_INSERT,
      OP_REMOVE,
      OP_TEMP,
      OP_RELEASE
   } op_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN_RD,
      S_SCAN_CMP,
      S_DECIDE,
      S_SHIFT_RD,
      S_SHIFT_WR,
      S_WRITE_NEW,
      S_RESPOND
   } state_type;

   typedef struct packed {
      logic load;
      logic scan_rd;
      logic scan_cmp;
      logic decide;
      logic shift_rd;
      logic shift_wr;
      logic write_new;
      logic respond;
   } cmd_type;

   typedef struct packed {
      logic scan_done;
      logic dec_shift;
      logic is_insert;
      logic shift_done;
   } stat_type;

endpackage

[src/iova_range_allocator.sv]
// top level of the iova range allocator: sequencer plus table datapath
// depends on ira_pkg, ira_ctrl, ira_dpath and iova_range_allocator_defines.svh
//
// channel   ports                                   transfer when
// request   start, busy, req_*                      start && !busy
// response  rsp_valid, rsp_*                        rsp_valid (one cycle, no stall)
//
// busy while the table is scanned (until a hit or the first entry above the host
// page) and while entries are moved on insert or remove, with a read state and a
// second state for each entry; scanned plus moved never exceeds TABLE_DEPTH, and
// the response shows in the cycle after the respond state
// each entry step goes through the single-port table memory with its registered read
// release skips the scan; unmap of host page 0 still scans the table
// synchronous reset empties the table and restores both marks; no clearing pass
// the response cannot be held off; busy drops in the cycle the response shows
`include "iova_range_allocator_defines.svh"
module iova_range_allocator #(
   parameter int TABLE_DEPTH    = ira_pkg::DEF_TABLE_DEPTH,
   parameter int IOVA_BITS      = ira_pkg::DEF_IOVA_BITS,
   parameter int PAGE_SHIFT     = ira_pkg::DEF_PAGE_SHIFT,
   parameter int HOST_ADDR_BITS = ira_pkg::DEF_HOST_ADDR_BITS
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [1:0]                        req_mode,
   input  logic [ira_pkg::HOST_PAGE_W-1:0]   req_host_page,
   input  logic [ira_pkg::SIZE_W-1:0]        req_size_pages,
   input  logic                              req_map_refused,
   output logic                              rsp_valid,
   output logic [ira_pkg::STATUS_W-1:0]      rsp_status,
   output logic [ira_pkg::IOVA_W-1:0]        rsp_iova_page,
   output logic [ira_pkg::RANGE_W-1:0]       rsp_range_pages
);
   import ira_pkg::*;

   // command and status between sequencer and datapath
   cmd_type  cmd;
   stat_type stat;

   // sequencer: walks scan, decision, table shift and response
   ira_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .stat  (stat),
      .cmd   (cmd)
   );

   // datapath: table memory, low and high marks, result registers
   ira_dpath #(
      .TABLE_DEPTH    (TABLE_DEPTH),
      .IOVA_BITS      (IOVA_BITS),
      .PAGE_SHIFT     (PAGE_SHIFT),
      .HOST_ADDR_BITS (HOST_ADDR_BITS)
   ) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .req_mode        (req_mode),
      .req_host_page   (req_host_page),
      .req_size_pages  (req_size_pages),
      .req_map_refused (req_map_refused),
      .rsp_valid       (rsp_valid),
      .rsp_status      (rsp_status),
      .rsp_iova_page   (rsp_iova_page),
      .rsp_range_pages (rsp_range_pages)
   );

   // a response only comes as the sequencer returns to idle
   `IRA_ASSERT_IMP(a_rsp_when_idle, rsp_valid, !busy, "response while busy")
   // an accepted request always starts work
   `IRA_ASSERT_NXT(a_accept_busy, start && !busy, busy, "request accepted but not busy")
   // a new mapping always covers at least one page
   `IRA_ASSERT_IMP(a_new_nonempty, rsp_valid && rsp_status == ST_NEW,
      rsp_range_pages != '0, "new mapping with empty range")

endmodule

[src/ira_ctrl.sv]
// sequencer of the iova range allocator: scan, decide, shift, respond
// depends on ira_pkg
module ira_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  ira_pkg::stat_type stat,
   output ira_pkg::cmd_type  cmd
);
   import ira_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = S_SCAN_RD;
            end
         end
         S_SCAN_RD: begin
            if (stat.scan_done) begin
               state_in = S_DECIDE;
            end else begin
               cmd.scan_rd = 1'b1;
               state_in    = S_SCAN_CMP;
            end
         end
         S_SCAN_CMP: begin
            cmd.scan_cmp = 1'b1;
            state_in     = S_SCAN_RD;
         end
         S_DECIDE: begin
            cmd.decide = 1'b1;
            state_in   = stat.dec_shift ? S_SHIFT_RD : S_RESPOND;
         end
         S_SHIFT_RD: begin
            if (stat.shift_done) begin
               state_in = stat.is_insert ? S_WRITE_NEW : S_RESPOND;
            end else begin
               cmd.shift_rd = 1'b1;
               state_in     = S_SHIFT_WR;
            end
         end
         S_SHIFT_WR: begin
            cmd.shift_wr = 1'b1;
            state_in     = S_SHIFT_RD;
         end
         S_WRITE_NEW: begin
            cmd.write_new = 1'b1;
            state_in      = S_RESPOND;
         end
         S_RESPOND: begin
            cmd.respond = 1'b1;
            state_in    = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign busy = (state_ff != S_IDLE);

endmodule

[src/ira_dpath.sv]
// datapath of the iova range allocator: sorted table memory, marks, result
// depends on ira_pkg
module ira_dpath #(
   parameter int TABLE_DEPTH    = ira_pkg::DEF_TABLE_DEPTH,
   parameter int IOVA_BITS      = ira_pkg::DEF_IOVA_BITS,
   parameter int PAGE_SHIFT     = ira_pkg::DEF_PAGE_SHIFT,
   parameter int HOST_ADDR_BITS = ira_pkg::DEF_HOST_ADDR_BITS
) (
   input  logic                              clock,
   input  logic                              reset,
   input  ira_pkg::cmd_type                  cmd,
   output ira_pkg::stat_type                 stat,
   input  logic [1:0]                        req_mode,
   input  logic [ira_pkg::HOST_PAGE_W-1:0]   req_host_page,
   input  logic [ira_pkg::SIZE_W-1:0]        req_size_pages,
   input  logic                              req_map_refused,
   output logic                              rsp_valid,
   output logic [ira_pkg::STATUS_W-1:0]      rsp_status,
   output logic [ira_pkg::IOVA_W-1:0]        rsp_iova_page,
   output logic [ira_pkg::RANGE_W-1:0]       rsp_range_pages
);
   import ira_pkg::*;

   localparam int IDX_W  = $clog2(TABLE_DEPTH);
   localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
   localparam int TOP_SH = IOVA_BITS - PAGE_SHIFT;
   localparam int MARK_W = (TOP_SH + 1 > SIZE_W) ? TOP_SH + 1 : SIZE_W;
   localparam int HP_W   = HOST_ADDR_BITS - PAGE_SHIFT;
   localparam logic [HOST_PAGE_W-1:0] HOST_MASK =
      (HP_W >= HOST_PAGE_W) ? '1 : ((HOST_PAGE_W'(1) << HP_W) - HOST_PAGE_W'(1));
   localparam logic [MARK_W-1:0] FLOOR_PAGE = MARK_W'(FLOOR_BYTES >> PAGE_SHIFT);
   localparam logic [MARK_W-1:0] TOP_PAGE   = MARK_W'(1) << TOP_SH;
   localparam logic [CNT_W-1:0]  DEPTH_CNT  = CNT_W'(TABLE_DEPTH);

   typedef struct packed {
      logic [HOST_PAGE_W-1:0] host;
      logic [SIZE_W-1:0]      size;
      logic [IOVA_W-1:0]      iova;
   } entry_type;

   entry_type mem [TABLE_DEPTH];
   entry_type rd_data_ff;

   // request capture
   logic [1:0]             mode_ff, mode_in;
   logic [HOST_PAGE_W-1:0] hp_ff, hp_in;
   logic [SIZE_W-1:0]      size_ff, size_in;
   logic                   refused_ff, refused_in;

   // scan state
   logic [CNT_W-1:0]       idx_ff, idx_in;
   logic                   stop_ff, stop_in;
   logic                   found_ff, found_in;
   logic                   above_ff, above_in;
   entry_type              hit_ff, hit_in;
   logic [HOST_PAGE_W-1:0] next_host_ff, next_host_in;

   // allocator state
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [MARK_W-1:0] low_ff, low_in;
   logic [MARK_W-1:0] high_ff, high_in;
   op_type            op_ff, op_in;
   logic [CNT_W-1:0]  sh_idx_ff, sh_idx_in;

   // result
   logic                  rsp_valid_ff, rsp_valid_in;
   status_type            res_status_ff, res_status_in;
   logic [IOVA_W-1:0]     res_iova_ff, res_iova_in;
   logic [RANGE_W-1:0]    res_range_ff, res_range_in;

   // decision
   status_type         dec_status;
   logic [IOVA_W-1:0]  dec_iova;
   logic [RANGE_W-1:0] dec_range;
   op_type             dec_op;

   logic [MARK_W-1:0]      size_ext;
   logic [MARK_W-1:0]      freed;
   logic [MARK_W-1:0]      room;
   logic [HOST_PAGE_W-1:0] hit_off;
   logic [HOST_PAGE_W:0]   new_end;
   logic                   contains;
   logic [HOST_PAGE_W-1:0] diff;
   logic [CNT_W-1:0]       rd_idx;
   logic [CNT_W-1:0]       wr_idx;
   entry_type              wr_data;
   logic                   wr_en;
   logic                   rd_en;

   assign size_ext = MARK_W'(size_ff);
   assign freed    = TOP_PAGE - high_ff;
   assign room     = high_ff - low_ff;
   assign hit_off  = hp_ff - hit_ff.host;
   assign new_end  = {1'b0, hp_ff} + (HOST_PAGE_W + 1)'(size_ff);
   assign diff     = hp_ff - rd_data_ff.host;
   assign contains = (rd_data_ff.host <= hp_ff) &&
                     (diff < HOST_PAGE_W'(rd_data_ff.size));

   always_comb begin
      dec_status = ST_NOT_FOUND;
      dec_iova   = '0;
      dec_range  = '0;
      dec_op     = OP_NONE;
      priority if (mode_ff == MODE_RELEASE) begin
         if (refused_ff) begin
            dec_status = ST_REFUSED;
         end else begin
            dec_status = ST_RELEASED;
            dec_iova   = (freed == '0) ? '0 : high_ff[IOVA_W-1:0];
            dec_range  = freed[RANGE_W-1:0];
            dec_op     = OP_RELEASE;
         end
      end else if (mode_ff == MODE_UNMAP) begin
         if (hp_ff != '0 && found_ff) begin
            dec_status = ST_UNMAPPED;
            dec_iova   = hit_ff.iova;
            dec_range  = hit_ff.size;
            dec_op     = OP_REMOVE;
         end
      end else if (found_ff) begin
         dec_status = ST_HIT;
         dec_iova   = hit_ff.iova + hit_off[IOVA_W-1:0];
      end else if (size_ff == '0 || room < size_ext) begin
         dec_status = ST_NO_SPACE;
      end else if (mode_ff == MODE_MAP_TEMP) begin
         if (refused_ff) begin
            dec_status = ST_REFUSED;
         end else begin
            dec_status = ST_NEW;
            dec_iova   = IOVA_W'(high_ff - size_ext);
            dec_range  = size_ff;
            dec_op     = OP_TEMP;
         end
      end else if (count_ff >= DEPTH_CNT) begin
         dec_status = ST_FULL;
      end else if (above_ff && ({1'b0, next_host_ff} < new_end)) begin
         dec_status = ST_OVERLAP;
      end else if (refused_ff) begin
         dec_status = ST_REFUSED;
      end else begin
         dec_status = ST_NEW;
         dec_iova   = low_ff[IOVA_W-1:0];
         dec_range  = size_ff;
         dec_op     = OP_INSERT;
      end
   end

   always_comb begin
      stat.scan_done  = stop_ff || (idx_ff >= count_ff);
      stat.dec_shift  = (dec_op == OP_INSERT) || (dec_op == OP_REMOVE);
      stat.is_insert  = (op_ff == OP_INSERT);
      stat.shift_done = (op_ff == OP_INSERT) ? (sh_idx_ff == idx_ff)
                                             : (sh_idx_ff + CNT_W'(1) >= count_ff);
   end

   // table port selection
   always_comb begin
      rd_en   = cmd.scan_rd || cmd.shift_rd;
      rd_idx  = cmd.scan_rd ? idx_ff
              : ((op_ff == OP_INSERT) ? sh_idx_ff - CNT_W'(1) : sh_idx_ff + CNT_W'(1));
      wr_en   = cmd.shift_wr || cmd.write_new;
      wr_idx  = cmd.write_new ? idx_ff : sh_idx_ff;
      wr_data = cmd.write_new
              ? entry_type'{host: hp_ff, size: size_ff, iova: low_ff[IOVA_W-1:0]}
              : rd_data_ff;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_idx[IDX_W-1:0]] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_idx[IDX_W-1:0]];
      end
   end

   always_comb begin
      mode_in       = mode_ff;
      hp_in         = hp_ff;
      size_in       = size_ff;
      refused_in    = refused_ff;
      idx_in        = idx_ff;
      stop_in       = stop_ff;
      found_in      = found_ff;
      above_in      = above_ff;
      hit_in        = hit_ff;
      next_host_in  = next_host_ff;
      count_in      = count_ff;
      low_in        = low_ff;
      high_in       = high_ff;
      op_in         = op_ff;
      sh_idx_in     = sh_idx_ff;
      rsp_valid_in  = cmd.respond;
      res_status_in = res_status_ff;
      res_iova_in   = res_iova_ff;
      res_range_in  = res_range_ff;

      if (cmd.load) begin
         mode_in    = req_mode;
         hp_in      = req_host_page & HOST_MASK;
         size_in    = req_size_pages;
         refused_in = req_map_refused;
         idx_in     = '0;
         stop_in    = (req_mode == MODE_RELEASE);
         found_in   = 1'b0;
         above_in   = 1'b0;
      end

      // entries are sorted and disjoint: stop at a hit or the first one above
      if (cmd.scan_cmp) begin
         if (contains) begin
            found_in = 1'b1;
            stop_in  = 1'b1;
            hit_in   = rd_data_ff;
         end else if (rd_data_ff.host > hp_ff) begin
            above_in     = 1'b1;
            stop_in      = 1'b1;
            next_host_in = rd_data_ff.host;
         end else begin
            idx_in = idx_ff + CNT_W'(1);
         end
      end

      if (cmd.decide) begin
         op_in         = dec_op;
         res_status_in = dec_status;
         res_iova_in   = dec_iova;
         res_range_in  = dec_range;
         sh_idx_in     = (dec_op == OP_INSERT) ? count_ff : idx_ff;
      end

      if (cmd.shift_wr) begin
         sh_idx_in = (op_ff == OP_INSERT) ? sh_idx_ff - CNT_W'(1)
                                          : sh_idx_ff + CNT_W'(1);
      end

      if (cmd.respond) begin
         unique case (op_ff)
            OP_INSERT: begin
               count_in = count_ff + CNT_W'(1);
               low_in   = low_ff + size_ext;
            end
            OP_REMOVE:  count_in = count_ff - CNT_W'(1);
            OP_TEMP:    high_in  = high_ff - size_ext;
            OP_RELEASE: high_in  = TOP_PAGE;
            OP_NONE:    ;
            default:    ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         low_ff       <= FLOOR_PAGE;
         high_ff      <= TOP_PAGE;
         op_ff        <= OP_NONE;
         rsp_valid_ff <= 1'b0;
         stop_ff      <= 1'b0;
         idx_ff       <= '0;
         sh_idx_ff    <= '0;
      end else begin
         count_ff     <= count_in;
         low_ff       <= low_in;
         high_ff      <= high_in;
         op_ff        <= op_in;
         rsp_valid_ff <= rsp_valid_in;
         stop_ff      <= stop_in;
         idx_ff       <= idx_in;
         sh_idx_ff    <= sh_idx_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff       <= mode_in;
      hp_ff         <= hp_in;
      size_ff       <= size_in;
      refused_ff    <= refused_in;
      found_ff      <= found_in;
      above_ff      <= above_in;
      hit_ff        <= hit_in;
      next_host_ff  <= next_host_in;
      res_status_ff <= res_status_in;
      res_iova_ff   <= res_iova_in;
      res_range_ff  <= res_range_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = res_status_ff;
   assign rsp_iova_page   = res_iova_ff;
   assign rsp_range_pages = res_range_ff;

endmodule

[tb/iova_range_allocator_tb.sv]
// testbench for the iova range allocator: random and directed map, unmap and release traffic
// depends on ira_pkg and the iova_range_allocator rtl; a scoreboard class predicts every response
`timescale 1ns / 1ps

module iova_range_allocator_tb;
   import ira_pkg::*;

   localparam int DEPTH = DEF_TABLE_DEPTH;
   localparam longint unsigned FLOOR_PG = FLOOR_BYTES >> DEF_PAGE_SHIFT;
   localparam longint unsigned TOP_PG = 64'd1 << (DEF_IOVA_BITS - DEF_PAGE_SHIFT);
   localparam int DRAIN_CYCLES = 4 * DEPTH + 40;

   // allocation tracker: mirrors the table and both marks, queues expected responses
   class alloc_scoreboard;
      bit [HOST_PAGE_W-1:0] map_host[DEPTH];
      bit [SIZE_W-1:0]      map_size[DEPTH];
      bit [IOVA_W-1:0]      map_iova[DEPTH];
      int                   map_count;
      longint unsigned      low_mark, high_mark;
      status_type           want_status[$];
      bit [IOVA_W-1:0]      want_iova[$];
      bit [RANGE_W-1:0]     want_range[$];
      int                   errors;

      function new();
         map_count = 0;
         low_mark  = FLOOR_PG;
         high_mark = TOP_PG;
         errors    = 0;
      endfunction

      function void push(status_type st, longint unsigned iova, longint unsigned rng);
         want_status.push_back(st);
         want_iova.push_back(iova[IOVA_W-1:0]);
         want_range.push_back(rng[RANGE_W-1:0]);
      endfunction

      function int lookup(longint unsigned hp);
         for (int i = 0; i < map_count; i++) begin
            if (map_host[i] <= hp && hp - map_host[i] < map_size[i]) return i;
         end
         return -1;
      endfunction

      // note one accepted request and predict its response
      function void note_request(mode_type mode, bit [HOST_PAGE_W-1:0] hp_in,
                                 bit [SIZE_W-1:0] sz_in, bit refused);
         longint unsigned hp, sz, freed;
         int idx, pos;
         hp = hp_in;
         sz = sz_in;
         if (mode == MODE_RELEASE) begin
            freed = TOP_PG - high_mark;
            if (refused) push(ST_REFUSED, 0, 0);
            else if (freed == 0) push(ST_RELEASED, 0, 0);
            else begin
               push(ST_RELEASED, high_mark, freed);
               high_mark = TOP_PG;
            end
            return;
         end
         if (mode == MODE_UNMAP) begin
            idx = (hp == 0) ? -1 : lookup(hp);
            if (idx < 0) begin
               push(ST_NOT_FOUND, 0, 0);
               return;
            end
            push(ST_UNMAPPED, map_iova[idx], map_size[idx]);
            for (int i = idx; i + 1 < map_count; i++) begin
               map_host[i] = map_host[i+1];
               map_size[i] = map_size[i+1];
               map_iova[i] = map_iova[i+1];
            end
            map_count--;
            return;
         end
         idx = lookup(hp);
         if (idx >= 0) begin
            push(ST_HIT, map_iova[idx] + (hp - map_host[idx]), 0);
            return;
         end
         if (sz == 0 || high_mark - low_mark < sz) begin
            push(ST_NO_SPACE, 0, 0);
            return;
         end
         if (mode == MODE_MAP_TEMP) begin
            if (refused) push(ST_REFUSED, 0, 0);
            else begin
               high_mark -= sz;
               push(ST_NEW, high_mark, sz);
            end
            return;
         end
         if (map_count >= DEPTH) begin
            push(ST_FULL, 0, 0);
            return;
         end
         pos = 0;
         while (pos < map_count && map_host[pos] < hp) pos++;
         if (pos < map_count && map_host[pos] < hp + sz) begin
            push(ST_OVERLAP, 0, 0);
            return;
         end
         if (refused) begin
            push(ST_REFUSED, 0, 0);
            return;
         end
         for (int i = map_count; i > pos; i--) begin
            map_host[i] = map_host[i-1];
            map_size[i] = map_size[i-1];
            map_iova[i] = map_iova[i-1];
         end
         map_host[pos] = hp[HOST_PAGE_W-1:0];
         map_size[pos] = sz[SIZE_W-1:0];
         map_iova[pos] = low_mark[IOVA_W-1:0];
         map_count++;
         push(ST_NEW, low_mark, sz);
         low_mark += sz;
      endfunction

      // compare one response against the oldest prediction
      function void check_response(bit [STATUS_W-1:0] st, bit [IOVA_W-1:0] iova,
                                   bit [RANGE_W-1:0] rng);
         status_type es;
         bit [IOVA_W-1:0] ei;
         bit [RANGE_W-1:0] er;
         if (want_status.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("unexpected response status=%0d iova=%h range=%h", st, iova, rng);
            return;
         end
         es = want_status.pop_front();
         ei = want_iova.pop_front();
         er = want_range.pop_front();
         if (st != es || iova != ei || rng != er) begin
            errors++;
            if (errors <= 10)
               $display("response differs: expected status=%0d iova=%h range=%h, got %0d %h %h",
                        es, ei, er, st, iova, rng);
         end
      endfunction
   endclass

   logic                   clock = 0;
   logic                   reset = 1;
   logic                   start = 0;
   logic                   busy;
   logic [1:0]             req_mode = MODE_MAP_FIXED;
   logic [HOST_PAGE_W-1:0] req_host_page = '0;
   logic [SIZE_W-1:0]      req_size_pages = '0;
   logic                   req_map_refused = 0;
   logic                   rsp_valid;
   logic [STATUS_W-1:0]    rsp_status;
   logic [IOVA_W-1:0]      rsp_iova_page;
   logic [RANGE_W-1:0]     rsp_range_pages;

   alloc_scoreboard tracker = new();
   int idle_pct = 0;
   bit [HOST_PAGE_W-1:0] host_base;

   iova_range_allocator dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_mode(req_mode), .req_host_page(req_host_page),
      .req_size_pages(req_size_pages), .req_map_refused(req_map_refused),
      .rsp_valid(rsp_valid), .rsp_status(rsp_status),
      .rsp_iova_page(rsp_iova_page), .rsp_range_pages(rsp_range_pages)
   );

   always #5 clock = ~clock;

   // every response strobe is one transfer, it cannot be stalled
   always @(posedge clock) begin
      if (!reset && rsp_valid) tracker.check_response(rsp_status, rsp_iova_page, rsp_range_pages);
   end

   // one request transfer; called and returns at a falling edge with start still high
   task automatic send_request(mode_type mode, bit [HOST_PAGE_W-1:0] hp,
                               bit [SIZE_W-1:0] sz, bit refused);
      // optional sender gap before this request
      if ($urandom_range(0, 99) < idle_pct) begin
         start <= 0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
      end
      start           <= 1;
      req_mode        <= mode;
      req_host_page   <= hp;
      req_size_pages  <= sz;
      req_map_refused <= refused;
      forever begin
         @(posedge clock);
         if (!busy) break;
      end
      tracker.note_request(mode, hp, sz, refused);
      @(negedge clock);
   endtask

   // host pages mostly from a small window of slots so hits and overlaps are common
   function automatic bit [HOST_PAGE_W-1:0] pick_host();
      int k;
      bit [63:0] wide;
      if ($urandom_range(0, 15) == 0) begin
         wide = {$urandom(), $urandom()};
         return wide[HOST_PAGE_W-1:0];
      end
      if (tracker.map_count > 0 && $urandom_range(0, 2) == 0) begin
         k = $urandom_range(0, tracker.map_count - 1);
         return tracker.map_host[k] + HOST_PAGE_W'($urandom_range(0, tracker.map_size[k]));
      end
      return host_base + HOST_PAGE_W'($urandom_range(0, 120) * 64 + $urandom_range(0, 70));
   endfunction

   function automatic bit [SIZE_W-1:0] pick_size(mode_type mode);
      int r;
      r = $urandom_range(0, 99);
      if (r < 3) return '0;
      if (r < 7) return SIZE_W'($urandom());
      if (mode == MODE_MAP_TEMP && r < 30) return SIZE_W'($urandom_range(1, 1 << 22));
      return SIZE_W'($urandom_range(1, 64));
   endfunction

   task automatic random_traffic(int count);
      mode_type mode;
      int r;
      for (int n = 0; n < count; n++) begin
         r = $urandom_range(0, 99);
         mode = (r < 48) ? MODE_MAP_FIXED : (r < 62) ? MODE_MAP_TEMP :
                (r < 88) ? MODE_UNMAP : MODE_RELEASE;
         send_request(mode, pick_host(), pick_size(mode), $urandom_range(0, 7) == 0);
      end
   endtask

   initial begin
      host_base = HOST_PAGE_W'($urandom()) & 36'hF_FFF0_0000;
      host_base = host_base | ({HOST_PAGE_W'($urandom())} << 32);
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // directed corner cases
      send_request(MODE_RELEASE,   0, 0, 0);                   // release with nothing held
      send_request(MODE_UNMAP,     0, 0, 0);                   // unmap host page zero
      send_request(MODE_UNMAP,     36'h123, 0, 0);             // unmap of unknown page
      send_request(MODE_MAP_FIXED, 36'h100, 0, 0);             // empty region
      send_request(MODE_MAP_FIXED, 36'h100, 28'hFFF_FFFF, 0);  // no space
      send_request(MODE_MAP_FIXED, 36'h100, 28'd8, 1);         // refused fixed map
      send_request(MODE_MAP_FIXED, 36'h100, 28'd8, 0);         // new fixed map
      send_request(MODE_MAP_FIXED, 36'h107, 28'd3, 1);         // hit, refusal ignored
      send_request(MODE_MAP_TEMP,  36'h104, 28'd3, 0);         // hit through temporary mode
      send_request(MODE_MAP_FIXED, 36'h0FC, 28'd5, 0);         // overlaps the next entry
      send_request(MODE_MAP_FIXED, 36'hF_FFFF_FFFF, 28'd1, 0); // top host page
      send_request(MODE_MAP_FIXED, 36'h0, 28'd1, 0);           // bottom host page
      send_request(MODE_MAP_TEMP,  36'h5000, 28'd16, 1);       // refused temporary map
      send_request(MODE_MAP_TEMP,  36'h5000, 28'd16, 0);
      send_request(MODE_MAP_TEMP,  36'h6000, 28'h400_0000, 0);
      send_request(MODE_MAP_TEMP,  36'h7000, 28'h800_0000, 0); // exceeds what is free
      send_request(MODE_RELEASE,   0, 0, 1);                   // refused release
      send_request(MODE_RELEASE,   0, 0, 0);
      send_request(MODE_UNMAP,     36'h105, 0, 1);             // removal ignores refusal
      send_request(MODE_UNMAP,     36'h105, 0, 0);
      send_request(MODE_UNMAP,     36'h0, 0, 0);               // page zero even though mapped
      // fill the table past its depth to reach the full status
      for (int i = 0; i < DEPTH + 2; i++)
         send_request(MODE_MAP_FIXED, 36'h20000 + HOST_PAGE_W'(i * 4), 28'd2, 0);

      idle_pct = 19;
      random_traffic(400);
      idle_pct = 83;
      random_traffic(400);
      idle_pct = 0;
      random_traffic(400);
      start <= 0;

      while (tracker.want_status.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (tracker.errors == 0) $display("iova_range_allocator: match");
      else $display("iova_range_allocator: mismatch");
      $finish;
   end

   // run limit, far beyond the slowest legal run
   initial begin
      #60ms;
      $display("iova_range_allocator: mismatch");
      $finish;
   end

endmodule
